/* sv/bid_pkg.sv */
// ----------------------------------------------------------------------------
// bid_pkg
// Shared types and codes for the bounded indexed deque.
// ----------------------------------------------------------------------------
package bid_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACTION_W       = 3;
    localparam int STATUS_W       = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPEND_BACK = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_BACK = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_INSERT_AT   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_EXTRACT_AT  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_DEL
    } t_op;

    typedef enum logic [1:0] {
        SEL_FRONT,
        SEL_BACK,
        SEL_POS
    } t_sel;

    typedef struct packed {
        logic                load;
        logic                exec;
        t_op                 op;
        t_sel                sel;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                full;
        logic                ins_pos_bad;
        logic                ext_pos_bad;
    } t_flags;

endpackage

/* sv/bounded_indexed_deque.sv */
// ----------------------------------------------------------------------------
// bounded_indexed_deque
// Bounded ordered store of data words with front, back and indexed
// insertion and removal.
// ----------------------------------------------------------------------------
// A request is transferred on a rising edge where start is high and busy is
// low; i_action selects push front, pop front, append back, remove back,
// insert at i_position or extract at i_position, and i_value_in carries the
// word to add.
// Every request produces exactly one result, shown for a single cycle with
// o_done high: o_status (ok, empty, full or bad position), o_value_out (the
// word removed, zero otherwise) and o_length (words stored afterwards).
// The request is held in the request registers; in the execute state it is
// decoded against the count, and the row of shifting cells and the result
// registers are updated together.
// busy is high for one cycle after each transfer, so a new request cannot be
// transferred until the single update of the cell row, which moves all cells
// at once, is done.
// The receiver cannot stall; a result not taken in its cycle is gone.
// A synchronous reset empties the store; stored words themselves are not
// cleared and are never visible past the current length.
// ----------------------------------------------------------------------------
module bounded_indexed_deque
    import bid_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int LEN_W     = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [LEN_W-1:0]      i_position,
    input  logic [DATA_WIDTH-1:0] i_value_in,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DATA_WIDTH-1:0] o_value_out,
    output logic [LEN_W-1:0]      o_length
);

    t_cmd   cmd;
    t_flags flags;

    bid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_flags (flags),
        .o_cmd   (cmd)
    );

    bid_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_value_in  (i_value_in),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_length    (o_length)
    );

endmodule

/* sv/bid_ctrl.sv */
// ----------------------------------------------------------------------------
// bid_ctrl
// Controller: accepts a request, decodes the action against the store
// status and commands one update of the cell array.
// ----------------------------------------------------------------------------
module bid_ctrl
    import bid_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                n_state = start ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy         = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.sel    = SEL_FRONT;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
                unique case (i_flags.action)
                    ACT_PUSH_FRONT, ACT_APPEND_BACK, ACT_INSERT_AT: begin
                        o_cmd.sel = (i_flags.action == ACT_PUSH_FRONT) ? SEL_FRONT :
                                    (i_flags.action == ACT_APPEND_BACK) ? SEL_BACK :
                                    SEL_POS;
                        if (i_flags.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (i_flags.action == ACT_INSERT_AT
                                     && i_flags.ins_pos_bad) begin
                            o_cmd.status = ST_BADPOS;
                        end else begin
                            o_cmd.op = OP_INS;
                        end
                    end
                    ACT_POP_FRONT, ACT_REMOVE_BACK, ACT_EXTRACT_AT: begin
                        o_cmd.sel = (i_flags.action == ACT_POP_FRONT) ? SEL_FRONT :
                                    (i_flags.action == ACT_REMOVE_BACK) ? SEL_BACK :
                                    SEL_POS;
                        if (i_flags.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else if (i_flags.action == ACT_EXTRACT_AT
                                     && i_flags.ext_pos_bad) begin
                            o_cmd.status = ST_BADPOS;
                        end else begin
                            o_cmd.op = OP_DEL;
                        end
                    end
                    default: begin
                        o_cmd.op = OP_NONE;
                    end
                endcase
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* sv/bid_dpath.sv */
// ----------------------------------------------------------------------------
// bid_dpath
// Datapath: request registers, a row of shifting cells, the word count
// and the result registers.
// ----------------------------------------------------------------------------
module bid_dpath
    import bid_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int LEN_W     = $clog2(CAPACITY + 1),
    localparam int IW        = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_flags                o_flags,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [LEN_W-1:0]      i_position,
    input  logic [DATA_WIDTH-1:0] i_value_in,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [DATA_WIDTH-1:0] o_value_out,
    output logic [LEN_W-1:0]      o_length
);

    logic [ACTION_W-1:0]   r_action;
    logic [LEN_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_word;
    logic [LEN_W-1:0]      r_count;
    logic [LEN_W-1:0]      n_count;
    logic [DATA_WIDTH-1:0] r_cells [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cells [CAPACITY];
    logic [IW-1:0]         idx;
    logic [DATA_WIDTH-1:0] removed;
    logic                  r_done;
    logic [STATUS_W-1:0]   r_status;
    logic [DATA_WIDTH-1:0] r_value_out;
    logic [LEN_W-1:0]      r_length;

    always_comb begin
        o_flags.action      = r_action;
        o_flags.empty       = (r_count == '0);
        o_flags.full        = (r_count == LEN_W'(CAPACITY));
        o_flags.ins_pos_bad = (r_pos > r_count);
        o_flags.ext_pos_bad = (r_pos >= r_count);
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_FRONT: idx = '0;
            SEL_BACK:  idx = (i_cmd.op == OP_INS) ? IW'(r_count) : IW'(r_count - 1'b1);
            SEL_POS:   idx = IW'(r_pos);
            default:   idx = '0;
        endcase
    end

    always_comb begin
        removed = '0;
        n_count = r_count;
        for (int k = 0; k < CAPACITY; k++) begin
            n_cells[k] = r_cells[k];
        end
        if (i_cmd.exec && i_cmd.op == OP_INS) begin
            n_count = r_count + 1'b1;
            for (int k = 0; k < CAPACITY; k++) begin
                if (IW'(k) == idx) begin
                    n_cells[k] = r_word;
                end else if (k > 0 && IW'(k) > idx) begin
                    n_cells[k] = r_cells[k - 1];
                end
            end
        end else if (i_cmd.exec && i_cmd.op == OP_DEL) begin
            n_count = r_count - 1'b1;
            removed = r_cells[idx];
            for (int k = 0; k < CAPACITY - 1; k++) begin
                if (IW'(k) >= idx) begin
                    n_cells[k] = r_cells[k + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_pos    <= i_position;
            r_word   <= i_value_in;
        end
        for (int k = 0; k < CAPACITY; k++) begin
            r_cells[k] <= n_cells[k];
        end
        if (i_cmd.exec) begin
            r_status    <= i_cmd.status;
            r_value_out <= removed;
            r_length    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.exec;
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_length    = r_length;

endmodule
